FILE: rtl/ias_pkg.sv
// Shared types and constants of the ignition advance scheduler.
`default_nettype none

package ias_pkg;

   localparam int TIME_BITS     = 32;
   localparam int SPEED_BITS    = 26;
   localparam int ANGLE_BITS    = 6;
   localparam int CSR_BITS      = 16;
   localparam int DIV_NUM_BITS  = SPEED_BITS;
   localparam int DIV_STEP_BITS = 6;

   localparam logic [SPEED_BITS-1:0]    SPEED_MAX    = '1;
   localparam logic [SPEED_BITS-1:0]    RPM_US       = 26'd60000000;
   localparam logic [ANGLE_BITS-1:0]    ANGLE_MAX    = 6'd38;
   localparam logic [CSR_BITS-1:0]      MIN_RPM_INIT = 16'd80;
   localparam logic [CSR_BITS-1:0]      CUT_RPM_INIT = 16'd3000;
   localparam logic [DIV_STEP_BITS-1:0] STEPS_SPEED  = 6'd26;

   typedef enum logic {
      CSR_MIN_RPM = 1'b0,
      CSR_CUT_RPM = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic load_in;
      logic div_start;
      logic spd_sat;
      logic spd_load;
      logic curve_mul;
      logic adv_load;
      logic q36_load;
      logic q10_load;
      logic split_load;
      logic offs_load;
      logic start_load;
      logic end_load;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic edge_seen;
      logic period_zero;
      logic div_busy;
      logic rsp_busy;
   } sts_type;

endpackage

`default_nettype wire

FILE: rtl/ias_divider.sv
// Bit-serial restoring divider, one quotient bit per clock cycle.
`default_nettype none

module ias_divider (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic [ias_pkg::DIV_NUM_BITS-1:0]     dividend,
   input  logic [ias_pkg::TIME_BITS-1:0]        divisor,
   input  logic [ias_pkg::DIV_STEP_BITS-1:0]    steps,
   output logic                                 busy,
   output logic [ias_pkg::DIV_NUM_BITS-1:0]     quotient
);

   logic [ias_pkg::DIV_STEP_BITS-1:0] count_ff;
   logic [ias_pkg::DIV_NUM_BITS-1:0]  num_ff;
   logic [ias_pkg::DIV_NUM_BITS-1:0]  quo_ff;
   logic [ias_pkg::TIME_BITS-1:0]     den_ff;
   logic [ias_pkg::TIME_BITS-1:0]     rem_ff;

   logic [ias_pkg::TIME_BITS:0]       trial;
   logic [ias_pkg::TIME_BITS:0]       diff;
   logic                              fits;
   logic [ias_pkg::TIME_BITS-1:0]     rem_in;

   assign trial  = {rem_ff, num_ff[ias_pkg::DIV_NUM_BITS-1]};
   assign fits   = trial >= {1'b0, den_ff};
   assign diff   = trial - {1'b0, den_ff};
   // The partial remainder always stays below the divisor, so it fits the time width.
   assign rem_in = fits ? diff[ias_pkg::TIME_BITS-1:0] : trial[ias_pkg::TIME_BITS-1:0];

   assign busy     = count_ff != '0;
   assign quotient = quo_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (start) begin
         count_ff <= steps;
         num_ff   <= dividend;
         den_ff   <= divisor;
         rem_ff   <= '0;
         quo_ff   <= '0;
      end else if (busy) begin
         count_ff <= count_ff - 1'b1;
         num_ff   <= {num_ff[ias_pkg::DIV_NUM_BITS-2:0], 1'b0};
         rem_ff   <= rem_in;
         quo_ff   <= {quo_ff[ias_pkg::DIV_NUM_BITS-2:0], fits};
      end
   end

endmodule

`default_nettype wire

FILE: rtl/ias_datapath.sv
// Datapath of the ignition advance scheduler: state, speed, curve, window and result register.
`default_nettype none

module ias_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write,
   input  logic                              csr_index,
   input  logic [ias_pkg::CSR_BITS-1:0]      csr_wdata,
   input  logic [ias_pkg::TIME_BITS-1:0]     req_now_us,
   input  logic                              req_sensor_level,
   input  logic                              req_limiter_level,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_coil_drive,
   output logic [ias_pkg::SPEED_BITS-1:0]    rsp_speed_rpm,
   output logic [ias_pkg::ANGLE_BITS-1:0]    rsp_advance_deg,
   input  ias_pkg::cmd_type                  cmd,
   output ias_pkg::sts_type                  sts
);

   // floor(x / 2000) equals (x * RECIP_2000) >> RECIP_SHIFT for every x below 2^18.
   localparam logic [17:0] RECIP_2000  = 18'd134218;
   localparam int          RECIP_SHIFT = 28;
   // floor(x / 9) equals (x * RECIP_9) >> RECIP_9_SHIFT for every x below 2^30.
   localparam logic [29:0] RECIP_9        = 30'd954437177;
   localparam int          RECIP_9_SHIFT  = 33;
   // floor(x / 10) equals (x * RECIP_10) >> RECIP_10_SHIFT for every x below 2^27.
   localparam logic [26:0] RECIP_10       = 27'd107374183;
   localparam int          RECIP_10_SHIFT = 30;
   // The same for x below 2^12, with a narrower factor.
   localparam logic [11:0] RECIP_10_LO       = 12'd3277;
   localparam int          RECIP_10_LO_SHIFT = 15;

   logic [ias_pkg::CSR_BITS-1:0]     min_rpm_ff;
   logic [ias_pkg::CSR_BITS-1:0]     cut_rpm_ff;
   logic [ias_pkg::TIME_BITS-1:0]    now_ff;
   logic                             sens_ff;
   logic                             lim_ff;
   logic                             prev_sensor_ff;
   logic [ias_pkg::TIME_BITS-1:0]    last_edge_ff;
   logic [ias_pkg::SPEED_BITS-1:0]   speed_ff;
   logic [ias_pkg::ANGLE_BITS-1:0]   advance_ff;
   logic [ias_pkg::TIME_BITS-1:0]    pending_start_ff;
   logic [ias_pkg::TIME_BITS-1:0]    pending_end_ff;
   logic [ias_pkg::TIME_BITS-1:0]    window_start_ff;
   logic [ias_pkg::TIME_BITS-1:0]    window_end_ff;
   logic [35:0]                      mul_ff;
   logic [26:0]                      q36_ff;
   logic [23:0]                      q10_ff;
   logic [32:0]                      offs_hi_ff;
   logic [11:0]                      offs_lo_ff;
   logic [ias_pkg::TIME_BITS-1:0]    offs_ff;
   logic                             rsp_valid_ff;
   logic                             rsp_coil_ff;
   logic [ias_pkg::SPEED_BITS-1:0]   rsp_speed_ff;
   logic [ias_pkg::ANGLE_BITS-1:0]   rsp_adv_ff;

   logic [ias_pkg::TIME_BITS-1:0]    period;
   logic                             div_busy;
   logic [ias_pkg::DIV_NUM_BITS-1:0] div_quo;

   logic [12:0]                      speed_lo;
   logic                             below_1000;
   logic                             below_3000;
   logic                             below_7000;
   logic [17:0]                      curve_x;
   logic [35:0]                      curve_prod;
   logic [ias_pkg::ANGLE_BITS-1:0]   curve_t;
   logic [6:0]                       angle_raw;
   logic [ias_pkg::ANGLE_BITS-1:0]   angle_new;
   logic [8:0]                       offs_k;
   logic [59:0]                      q36_prod;
   logic [53:0]                      q10_prod;
   logic [3:0]                       times10_lo;
   logic [3:0]                       rem10;
   logic [32:0]                      hi_prod;
   logic [11:0]                      lo_prod;
   logic [23:0]                      lo_wide;
   logic [8:0]                       lo_tenth;
   logic [32:0]                      offs_sum;
   logic                             coil_active;

   assign period = now_ff - last_edge_ff;

   ias_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (ias_pkg::RPM_US),
      .divisor  (period),
      .steps    (ias_pkg::STEPS_SPEED),
      .busy     (div_busy),
      .quotient (div_quo)
   );

   // The curve is only evaluated for speeds below 7000, which need 13 bits.
   assign speed_lo   = speed_ff[12:0];
   assign below_1000 = speed_ff < 26'd1000;
   assign below_3000 = speed_ff < 26'd3000;
   assign below_7000 = speed_ff < 26'd7000;
   assign curve_x    = below_3000 ? ({5'b0, speed_lo} * 18'd27) : {2'b0, speed_lo, 3'b0};
   assign curve_prod = {18'b0, curve_x} * {18'b0, RECIP_2000};
   assign curve_t    = mul_ff[RECIP_SHIFT +: ias_pkg::ANGLE_BITS];

   always_comb begin
      if (below_1000) begin
         angle_raw = 7'd2;
      end else if (below_3000) begin
         angle_raw = {1'b0, curve_t} - 7'd10;
      end else if (below_7000) begin
         angle_raw = {1'b0, curve_t} + 7'd18;
      end else begin
         angle_raw = {1'b0, advance_ff};
      end
   end

   assign angle_new = (angle_raw > {1'b0, ias_pkg::ANGLE_MAX}) ? ias_pkg::ANGLE_MAX
                                                               : angle_raw[5:0];

   // Offset is floor(floor(period / 36) * (360 - angle) / 10), never wider than the period.
   // The quotient by 36 is a quarter of the period divided by nine; the division by ten is
   // split into whole tens and a small remainder product so that nothing overflows.
   assign offs_k     = 9'd360 - {3'b0, advance_ff};
   assign q36_prod   = {30'b0, period[ias_pkg::TIME_BITS-1:2]} * {30'b0, RECIP_9};
   assign q10_prod   = {27'b0, q36_ff} * {27'b0, RECIP_10};
   // Ten times the whole tens, modulo 16; the remainder is below ten, so four bits hold it.
   assign times10_lo = {q10_ff[0], 3'b0} + {q10_ff[2:0], 1'b0};
   assign rem10      = q36_ff[3:0] - times10_lo;
   assign hi_prod    = {9'b0, q10_ff} * {24'b0, offs_k};
   assign lo_prod    = {8'b0, rem10} * {3'b0, offs_k};
   assign lo_wide    = {12'b0, offs_lo_ff} * {12'b0, RECIP_10_LO};
   assign lo_tenth   = lo_wide[RECIP_10_LO_SHIFT +: 9];
   assign offs_sum   = offs_hi_ff + {24'b0, lo_tenth};

   assign coil_active = (window_start_ff < now_ff) && (now_ff < window_end_ff)
                        && (speed_ff > ias_pkg::SPEED_BITS'(min_rpm_ff))
                        && (!lim_ff || (speed_ff < ias_pkg::SPEED_BITS'(cut_rpm_ff)));

   always_ff @(posedge clock) begin
      if (reset) begin
         min_rpm_ff       <= ias_pkg::MIN_RPM_INIT;
         cut_rpm_ff       <= ias_pkg::CUT_RPM_INIT;
         prev_sensor_ff   <= 1'b0;
         last_edge_ff     <= '0;
         speed_ff         <= '0;
         advance_ff       <= '0;
         pending_start_ff <= '0;
         pending_end_ff   <= '0;
         window_start_ff  <= '0;
         window_end_ff    <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (csr_write) begin
            unique case (ias_pkg::csr_index_type'(csr_index))
               ias_pkg::CSR_MIN_RPM: min_rpm_ff <= csr_wdata;
               ias_pkg::CSR_CUT_RPM: cut_rpm_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (cmd.load_in) begin
            now_ff  <= req_now_us;
            sens_ff <= req_sensor_level;
            lim_ff  <= req_limiter_level;
         end
         if (cmd.spd_sat) begin
            speed_ff <= ias_pkg::SPEED_MAX;
         end else if (cmd.spd_load) begin
            speed_ff <= div_quo[ias_pkg::SPEED_BITS-1:0];
         end
         if (cmd.curve_mul) begin
            mul_ff <= curve_prod;
         end
         if (cmd.adv_load) begin
            advance_ff <= angle_new;
         end
         if (cmd.q36_load) begin
            q36_ff <= q36_prod[RECIP_9_SHIFT +: 27];
         end
         if (cmd.q10_load) begin
            q10_ff <= q10_prod[RECIP_10_SHIFT +: 24];
         end
         if (cmd.split_load) begin
            offs_hi_ff <= hi_prod;
            offs_lo_ff <= lo_prod;
         end
         if (cmd.offs_load) begin
            offs_ff <= offs_sum[ias_pkg::TIME_BITS-1:0];
         end
         if (cmd.start_load) begin
            pending_start_ff <= now_ff + offs_ff;
         end
         if (cmd.end_load) begin
            pending_end_ff <= pending_start_ff + (period >> 2);
            last_edge_ff   <= now_ff;
         end
         if (cmd.finish) begin
            prev_sensor_ff <= sens_ff;
            if (!coil_active) begin
               window_start_ff <= pending_start_ff;
               window_end_ff   <= pending_end_ff;
            end
            rsp_valid_ff <= 1'b1;
            rsp_coil_ff  <= !coil_active;
            rsp_speed_ff <= speed_ff;
            rsp_adv_ff   <= advance_ff;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign sts.edge_seen   = prev_sensor_ff && !sens_ff;
   assign sts.period_zero = period == '0;
   assign sts.div_busy    = div_busy;
   assign sts.rsp_busy    = rsp_valid_ff && !rsp_ready;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_coil_drive  = rsp_coil_ff;
   assign rsp_speed_rpm   = rsp_speed_ff;
   assign rsp_advance_deg = rsp_adv_ff;

endmodule

`default_nettype wire

FILE: rtl/ias_controller.sv
// Sequencer of the ignition advance scheduler: steps one sample through the datapath.
`default_nettype none

module ias_controller (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  ias_pkg::sts_type    sts,
   output ias_pkg::cmd_type    cmd
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DIV_SPEED,
      ST_CURVE,
      ST_ADVANCE,
      ST_SPLIT,
      ST_OFFSET,
      ST_PEND_START,
      ST_PEND_END,
      ST_WINDOW
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_ready  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_in = 1'b1;
               state_in    = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (!sts.edge_seen) begin
               state_in = ST_WINDOW;
            end else if (sts.period_zero) begin
               cmd.spd_sat = 1'b1;
               state_in    = ST_CURVE;
            end else begin
               cmd.div_start = 1'b1;
               state_in      = ST_DIV_SPEED;
            end
         end
         ST_DIV_SPEED: begin
            if (!sts.div_busy) begin
               cmd.spd_load = 1'b1;
               state_in     = ST_CURVE;
            end
         end
         ST_CURVE: begin
            cmd.curve_mul = 1'b1;
            cmd.q36_load  = 1'b1;
            state_in      = ST_ADVANCE;
         end
         ST_ADVANCE: begin
            cmd.adv_load = 1'b1;
            cmd.q10_load = 1'b1;
            state_in     = ST_SPLIT;
         end
         ST_SPLIT: begin
            cmd.split_load = 1'b1;
            state_in       = ST_OFFSET;
         end
         ST_OFFSET: begin
            cmd.offs_load = 1'b1;
            state_in      = ST_PEND_START;
         end
         ST_PEND_START: begin
            cmd.start_load = 1'b1;
            state_in       = ST_PEND_END;
         end
         ST_PEND_END: begin
            cmd.end_load = 1'b1;
            state_in     = ST_WINDOW;
         end
         ST_WINDOW: begin
            // The result register must be free, or be emptied in this cycle.
            if (!sts.rsp_busy) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/ignition_advance_scheduler_unit.sv
// Top level of the ignition advance scheduler: sequencer, datapath and checks.
`default_nettype none

// Each transaction on the req_ channel is one sample of microsecond time, crank
// sensor and limiter pin; each yields exactly one transaction on the rsp_ channel
// with the coil level, the latest speed and the advance angle. Samples are handled
// one at a time. A sample without a falling sensor edge passes only through the
// check and the window step; one with a falling edge also runs the 26-step
// bit-serial divide for the speed (skipped when the period is zero), followed by
// the curve lookup and reciprocal multiplications that place the spark window.
// The result is presented in the cycle after the last step, and the next sample
// may be accepted in that same cycle, even while the result still waits; a result
// that is still held when the following one is ready stalls the block until it is
// taken. min_rpm and cut_rpm are written through the csr_ port; the user must write
// them only while no sample is in flight, as the block itself does not enforce
// this.
module ignition_advance_scheduler_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write,
   input  logic                              csr_index,
   input  logic [ias_pkg::CSR_BITS-1:0]      csr_wdata,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [ias_pkg::TIME_BITS-1:0]     req_now_us,
   input  logic                              req_sensor_level,
   input  logic                              req_limiter_level,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_coil_drive,
   output logic [ias_pkg::SPEED_BITS-1:0]    rsp_speed_rpm,
   output logic [ias_pkg::ANGLE_BITS-1:0]    rsp_advance_deg
);

   ias_pkg::cmd_type cmd;
   ias_pkg::sts_type sts;

   ias_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   ias_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .csr_write         (csr_write),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_now_us        (req_now_us),
      .req_sensor_level  (req_sensor_level),
      .req_limiter_level (req_limiter_level),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_coil_drive    (rsp_coil_drive),
      .rsp_speed_rpm     (rsp_speed_rpm),
      .rsp_advance_deg   (rsp_advance_deg),
      .cmd               (cmd),
      .sts               (sts)
   );

   // A divide is never launched on top of one still running.
   a_div_start_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |-> !sts.div_busy)
      else $error("divider started while busy");

   // No new sample is taken while the divider works on the current one.
   a_busy_no_accept: assert property (@(posedge clock) disable iff (reset)
      sts.div_busy |-> !req_ready)
      else $error("sample accepted during a divide");

   // Completing a sample always presents its result in the next cycle.
   a_finish_result: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> rsp_valid)
      else $error("finished sample left no result");

   // The presented angle always lies within the clamp.
   a_angle_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_advance_deg <= ias_pkg::ANGLE_MAX)
      else $error("advance angle out of range");

endmodule

`default_nettype wire

FILE: test/tb.sv
// Self-checking testbench of the ignition advance scheduler unit.
`timescale 1ns / 1ps

typedef struct packed {
   logic                           coil;
   logic [ias_pkg::SPEED_BITS-1:0] rpm;
   logic [ias_pkg::ANGLE_BITS-1:0] angle;
} spark_sample_type;

class spark_scoreboard;
   logic [ias_pkg::CSR_BITS-1:0]   floor_rpm;
   logic [ias_pkg::CSR_BITS-1:0]   limit_rpm;
   logic                           last_level;
   logic [ias_pkg::TIME_BITS-1:0]  prev_edge_us;
   logic [ias_pkg::SPEED_BITS-1:0] rpm;
   logic [ias_pkg::ANGLE_BITS-1:0] angle;
   logic [ias_pkg::TIME_BITS-1:0]  next_open;
   logic [ias_pkg::TIME_BITS-1:0]  next_close;
   logic [ias_pkg::TIME_BITS-1:0]  open_us;
   logic [ias_pkg::TIME_BITS-1:0]  close_us;
   spark_sample_type               owed[$];
   int                             checked;
   int                             mismatches;
   int                             crank_edges;
   int                             sparks;

   function new();
      floor_rpm    = ias_pkg::MIN_RPM_INIT;
      limit_rpm    = ias_pkg::CUT_RPM_INIT;
      last_level   = 1'b0;
      prev_edge_us = '0;
      rpm          = '0;
      angle        = '0;
      next_open    = '0;
      next_close   = '0;
      open_us      = '0;
      close_us     = '0;
      checked      = 0;
      mismatches   = 0;
      crank_edges  = 0;
      sparks       = 0;
   endfunction

   function void write_reg(ias_pkg::csr_index_type idx, logic [ias_pkg::CSR_BITS-1:0] value);
      case (idx)
         ias_pkg::CSR_MIN_RPM: floor_rpm = value;
         ias_pkg::CSR_CUT_RPM: limit_rpm = value;
         default: ;
      endcase
   endfunction

   // Advance curve; at 7000 rpm and above the previous angle stands.
   function logic [ias_pkg::ANGLE_BITS-1:0] curve_angle(
         logic [ias_pkg::SPEED_BITS-1:0] speed, logic [ias_pkg::ANGLE_BITS-1:0] held);
      logic [31:0] a;
      if (speed < 1000)
         a = 2;
      else if (speed < 3000)
         a = 27 * speed / 2000 - 10;
      else if (speed < 7000)
         a = 8 * speed / 2000 + 18;
      else
         a = 32'(held);
      if (a > ias_pkg::ANGLE_MAX)
         a = 32'(ias_pkg::ANGLE_MAX);
      return a[ias_pkg::ANGLE_BITS-1:0];
   endfunction

   function void note_sample(logic [ias_pkg::TIME_BITS-1:0] t, logic level, logic limiter);
      logic [ias_pkg::TIME_BITS-1:0] span;
      logic [63:0]                   q;
      logic [63:0]                   k;
      logic [63:0]                   offs;
      spark_sample_type              r;
      if (last_level && !level) begin
         span = t - prev_edge_us;
         if (span == 0)
            rpm = ias_pkg::SPEED_MAX;
         else
            rpm = ias_pkg::SPEED_BITS'(ias_pkg::RPM_US / span);
         angle = curve_angle(rpm, angle);
         // The offset is split so that the product never overflows.
         q = span / 36;
         k = 360 - angle;
         offs = (q / 10) * k + ((q % 10) * k) / 10;
         next_open  = t + offs[ias_pkg::TIME_BITS-1:0];
         next_close = next_open + span / 4;
         prev_edge_us = t;
         crank_edges++;
      end
      last_level = level;
      // The window test compares times plainly, without regard to wrap.
      if (open_us < t && t < close_us && rpm > floor_rpm && (!limiter || rpm < limit_rpm)) begin
         r.coil = 1'b0;
         sparks++;
      end else begin
         open_us  = next_open;
         close_us = next_close;
         r.coil   = 1'b1;
      end
      r.rpm   = rpm;
      r.angle = angle;
      owed.push_back(r);
   endfunction

   function void check_result(logic coil, logic [ias_pkg::SPEED_BITS-1:0] speed,
                              logic [ias_pkg::ANGLE_BITS-1:0] adv);
      spark_sample_type want;
      if (owed.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("%0t: result with none outstanding: coil %0b rpm %0d angle %0d",
                     $time, coil, speed, adv);
         return;
      end
      want = owed.pop_front();
      checked++;
      if (want.coil !== coil || want.rpm !== speed || want.angle !== adv) begin
         mismatches++;
         if (mismatches <= 10)
            $display("%0t: mismatch: coil %0b/%0b rpm %0d/%0d angle %0d/%0d (expected/actual)",
                     $time, want.coil, coil, want.rpm, speed, want.angle, adv);
      end
   endfunction
endclass

module tb;

   localparam int CYCLE_LIMIT = 1000000;
   localparam int HOLD_CYCLES = 600;

   localparam int PHASE_GOAL [6] = '{350, 650, 900, 1150, 1400, 1650};
   localparam logic [ias_pkg::CSR_BITS-1:0] PHASE_MIN [6] = '{16'd80, 16'd0, 16'd65535,
                                                             16'd1000, 16'd0, 16'd0};
   localparam logic [ias_pkg::CSR_BITS-1:0] PHASE_CUT [6] = '{16'd3000, 16'd0, 16'd65535,
                                                             16'd6000, 16'd0, 16'd65535};
   localparam int unsigned CORNER_SPANS [7] = '{60000, 60001, 20000, 20001, 8571, 8572,
                                               750000};

   // Opening samples: time, sensor level, limiter level.
   localparam logic [ias_pkg::TIME_BITS+1:0] OPENING [25] = '{
      {32'd0, 1'b0, 1'b0},
      {32'd5000, 1'b1, 1'b1},
      // First edge is measured from time zero: 3000 rpm.
      {32'd20000, 1'b0, 1'b0},
      // Another edge at the same time saturates the speed.
      {32'd20000, 1'b1, 1'b0},
      {32'd20000, 1'b0, 1'b1},
      {32'd80000, 1'b1, 1'b0},
      {32'd140000, 1'b0, 1'b0},
      {32'd150000, 1'b1, 1'b0},
      {32'd200000, 1'b0, 1'b0},
      {32'd205000, 1'b1, 1'b0},
      {32'd208571, 1'b0, 1'b0},
      {32'd210000, 1'b1, 1'b0},
      {32'd219000, 1'b0, 1'b0},
      {32'd225000, 1'b1, 1'b1},
      {32'd240000, 1'b0, 1'b1},
      {32'd245000, 1'b1, 1'b0},
      {32'd260000, 1'b0, 1'b0},
      // Promote the window, then fire inside it, once blocked by the limiter.
      {32'd270000, 1'b1, 1'b0},
      {32'd280000, 1'b1, 1'b0},
      {32'd281000, 1'b1, 1'b1},
      {32'd282000, 1'b1, 1'b0},
      // Edges either side of the time wrap.
      {32'hFFFF0000, 1'b1, 1'b0},
      {32'hFFFF8000, 1'b0, 1'b0},
      {32'hFFFFC000, 1'b1, 1'b1},
      {32'h00004000, 1'b0, 1'b0}
   };

   logic                           clock             = 1'b0;
   logic                           reset             = 1'b1;
   logic                           csr_write         = 1'b0;
   logic                           csr_index         = 1'b0;
   logic [ias_pkg::CSR_BITS-1:0]   csr_wdata         = '0;
   logic                           req_valid         = 1'b0;
   logic                           req_ready;
   logic [ias_pkg::TIME_BITS-1:0]  req_now_us        = '0;
   logic                           req_sensor_level  = 1'b0;
   logic                           req_limiter_level = 1'b0;
   logic                           rsp_valid;
   logic                           rsp_ready         = 1'b0;
   logic                           rsp_coil_drive;
   logic [ias_pkg::SPEED_BITS-1:0] rsp_speed_rpm;
   logic [ias_pkg::ANGLE_BITS-1:0] rsp_advance_deg;

   spark_scoreboard               sb = new();
   logic [ias_pkg::TIME_BITS-1:0] engine_us  = '0;
   int                            sent       = 0;
   int                            n_settings = 0;
   int                            cycles     = 0;
   int                            hold_left  = 0;
   bit                            hold_done  = 1'b0;
   bit                            want_hold  = 1'b0;
   bit                            calm       = 1'b0;

   ignition_advance_scheduler_unit DUT (
      .clock             (clock),
      .reset             (reset),
      .csr_write         (csr_write),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_now_us        (req_now_us),
      .req_sensor_level  (req_sensor_level),
      .req_limiter_level (req_limiter_level),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_coil_drive    (rsp_coil_drive),
      .rsp_speed_rpm     (rsp_speed_rpm),
      .rsp_advance_deg   (rsp_advance_deg)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Result side: check each transaction, then choose the next ready level.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_result(rsp_coil_drive, rsp_speed_rpm, rsp_advance_deg);
      if (want_hold && !hold_done) begin
         hold_left = HOLD_CYCLES;
         hold_done = 1'b1;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= calm || ($urandom_range(99) >= 25);
      end
   end

   initial begin
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("** ignition_advance_scheduler_unit: FAILED **");
      $finish;
   end

   task automatic send_sample(input logic [ias_pkg::TIME_BITS-1:0] t, input logic level,
                              input logic limiter);
      while (!calm && $urandom_range(99) < 25) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_now_us        <= t;
      req_sensor_level  <= level;
      req_limiter_level <= limiter;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      sb.note_sample(t, level, limiter);
      sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (sb.owed.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_limits(input logic [ias_pkg::CSR_BITS-1:0] lo,
                             input logic [ias_pkg::CSR_BITS-1:0] hi);
      csr_write <= 1'b1;
      csr_index <= ias_pkg::CSR_MIN_RPM;
      csr_wdata <= lo;
      @(posedge clock);
      sb.write_reg(ias_pkg::CSR_MIN_RPM, lo);
      csr_index <= ias_pkg::CSR_CUT_RPM;
      csr_wdata <= hi;
      @(posedge clock);
      sb.write_reg(ias_pkg::CSR_CUT_RPM, hi);
      csr_write <= 1'b0;
      n_settings++;
   endtask

   function automatic int unsigned pick_period();
      case ($urandom_range(10))
         0: return $urandom_range(200, 1);
         1: return $urandom_range(8571, 200);
         2, 3: return $urandom_range(20000, 8571);
         4, 5, 6: return $urandom_range(60000, 20000);
         7, 8: return $urandom_range(750000, 60000);
         9: return $urandom_range(5000000, 750000);
         default: return CORNER_SPANS[$urandom_range(6)];
      endcase
   endfunction

   // One crank revolution: falling edge first, sensor high for the second half.
   task automatic spin();
      int unsigned                   span;
      int unsigned                   steps;
      int unsigned                   lim_mode;
      int unsigned                   jit;
      logic [ias_pkg::TIME_BITS-1:0] t;
      logic                          lim;
      span     = pick_period();
      steps    = $urandom_range(20, 4);
      lim_mode = $urandom_range(2);
      if ($urandom_range(39) == 0)
         engine_us = '1 - span * $urandom_range(2) - $urandom_range(span);
      for (int i = 0; i < steps; i++) begin
         jit = (i == 0) ? 0 : $urandom_range(span / (4 * steps));
         t   = ias_pkg::TIME_BITS'(engine_us + longint'(i) * span / steps + jit);
         lim = (lim_mode == 2) ? 1'($urandom_range(1)) : lim_mode[0];
         send_sample(t, i >= steps / 2, lim);
         if (i == 0 && $urandom_range(19) == 0) begin
            send_sample(t, 1'b1, lim);
            send_sample(t, 1'b0, lim);
         end
      end
      engine_us = engine_us + span;
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      foreach (OPENING[i])
         send_sample(OPENING[i][ias_pkg::TIME_BITS+1:2], OPENING[i][1], OPENING[i][0]);
      engine_us = 32'h0010_0000;
      for (int p = 0; p < 6; p++) begin
         if (p > 0) begin
            drain();
            if (p == 4)
               set_limits(ias_pkg::CSR_BITS'($urandom), ias_pkg::CSR_BITS'($urandom));
            else
               set_limits(PHASE_MIN[p], PHASE_CUT[p]);
         end
         calm = (p == 1);
         // Stall the result side while samples keep coming.
         if (p == 2)
            want_hold = 1'b1;
         while (sent < PHASE_GOAL[p]) begin
            if ($urandom_range(99) < 85)
               spin();
            else
               repeat ($urandom_range(6, 1))
                  send_sample($urandom, 1'($urandom_range(1)), 1'($urandom_range(1)));
         end
      end
      drain();
      repeat (110) @(posedge clock);
      $display("Samples sent %0d, results checked %0d, crank edges %0d, firing samples %0d,",
               sent, sb.checked, sb.crank_edges, sb.sparks);
      $display("speed limit settings %0d, mismatches %0d, results outstanding %0d.",
               n_settings, sb.mismatches, sb.owed.size());
      if (sb.mismatches == 0 && sb.owed.size() == 0)
         $display("** ignition_advance_scheduler_unit: PASSED **");
      else
         $display("** ignition_advance_scheduler_unit: FAILED **");
      $finish;
   end

endmodule
